### rtl/fplet_pkg.sv
// Shared types and constants for the frame-pinned LRU entry table.
// Used by the controller, the datapath and the top level.
`default_nettype none

package fplet_pkg;

	localparam int ENTRIES = 16;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int KEY_W   = 32;
	localparam int FRAME_W = 32;
	localparam int SLOT_W  = 4;
	localparam int STAT_W  = 3;
	localparam int KIND_W  = 2;
	localparam int OUT_W   = STAT_W + SLOT_W + KEY_W + 1;

	typedef enum logic [KIND_W-1:0] {
		KIND_ACCESS  = 2'd0,
		KIND_ADVANCE = 2'd1,
		KIND_FLUSH   = 2'd2,
		KIND_NONE    = 2'd3
	} kind_t;

	typedef enum logic [STAT_W-1:0] {
		ST_HIT     = 3'd0,
		ST_ALLOC   = 3'd1,
		ST_EVICT   = 3'd2,
		ST_REFUSED = 3'd3,
		ST_ACK     = 3'd4
	} status_t;

	typedef struct packed {
		logic capture;
		logic step;
		logic commit;
	} dp_cmd_t;

	typedef struct packed {
		logic  is_access;
		logic  scan_last;
		logic  out_free;
	} dp_stat_t;

endpackage

`default_nettype wire

### rtl/fplet_ctrl.sv
// Sequencer for the entry table: capture, scan the slots for an access, commit.
// Depends on fplet_pkg for the command and status structs.
`default_nettype none

module fplet_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire fplet_pkg::dp_stat_t stat,
	output fplet_pkg::dp_cmd_t      cmd
);
	import fplet_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_SCAN   = 3'b010,
		S_COMMIT = 3'b100
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		cmd        = '0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_SCAN;
				end
			end
			S_SCAN: begin
				if (!stat.is_access) begin
					state_d = S_COMMIT;
				end else begin
					cmd.step = 1'b1;
					if (stat.scan_last) state_d = S_COMMIT;
				end
			end
			S_COMMIT: begin
				if (stat.out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

endmodule

`default_nettype wire

### rtl/fplet_dp.sv
// Datapath: key and stamp stores, occupancy bits, frame counter, scan
// trackers and the result register. Depends on fplet_pkg.
`default_nettype none

module fplet_dp (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire fplet_pkg::dp_cmd_t              cmd,
	output fplet_pkg::dp_stat_t                  stat,
	input  wire logic [fplet_pkg::KIND_W-1:0]    in_kind,
	input  wire logic [fplet_pkg::KEY_W-1:0]     in_key,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [fplet_pkg::OUT_W-1:0]          out_word
);
	import fplet_pkg::*;

	logic [KEY_W-1:0]   keys_q   [ENTRIES];
	logic [FRAME_W-1:0] stamps_q [ENTRIES];
	logic [ENTRIES-1:0] occ_q;
	logic [FRAME_W-1:0] frame_q;

	kind_t            kind_q;
	logic [KEY_W-1:0] key_q;
	logic [IDX_W-1:0] idx_q;

	logic             hit_q, free_q, vic_q;
	logic [IDX_W-1:0] hit_slot_q, free_slot_q, vic_slot_q;
	logic [FRAME_W-1:0] vic_stamp_q;
	logic [KEY_W-1:0] vic_key_q;

	logic             out_vld_q;
	status_t          res_status_q;
	logic [SLOT_W-1:0] res_slot_q;
	logic [KEY_W-1:0] res_evkey_q;
	logic             res_ev_q;

	logic             cur_occ;
	logic [KEY_W-1:0] cur_key;
	logic [FRAME_W-1:0] cur_stamp;
	logic             vic_take;

	logic             wr_en;
	logic [IDX_W-1:0] wr_idx;
	status_t          nxt_status;
	logic [IDX_W-1:0] nxt_slot;
	logic [IDX_W+SLOT_W-1:0] slot_ext;

	assign cur_occ   = occ_q[idx_q];
	assign cur_key   = keys_q[idx_q];
	assign cur_stamp = stamps_q[idx_q];
	assign vic_take  = cur_occ && (cur_stamp < frame_q) && (!vic_q || cur_stamp < vic_stamp_q);

	assign stat.is_access = (kind_q == KIND_ACCESS);
	assign stat.scan_last = (idx_q == IDX_W'(ENTRIES - 1));
	assign stat.out_free  = !out_vld_q || out_ready;

	always_comb begin
		wr_en      = 1'b0;
		wr_idx     = '0;
		nxt_slot   = '0;
		nxt_status = ST_ACK;
		if (kind_q == KIND_ACCESS) begin
			priority if (hit_q) begin
				nxt_status = ST_HIT;
				nxt_slot   = hit_slot_q;
				wr_en      = 1'b1;
				wr_idx     = hit_slot_q;
			end else if (free_q) begin
				nxt_status = ST_ALLOC;
				nxt_slot   = free_slot_q;
				wr_en      = 1'b1;
				wr_idx     = free_slot_q;
			end else if (vic_q) begin
				nxt_status = ST_EVICT;
				nxt_slot   = vic_slot_q;
				wr_en      = 1'b1;
				wr_idx     = vic_slot_q;
			end else begin
				nxt_status = ST_REFUSED;
			end
		end
	end

	assign slot_ext = {{SLOT_W{1'b0}}, nxt_slot};

	// store writes: key stays the same on a hit, so rewrite it unconditionally
	always_ff @(posedge clk) begin
		if (cmd.commit && wr_en) begin
			keys_q[wr_idx]   <= key_q;
			stamps_q[wr_idx] <= frame_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= kind_t'(in_kind);
			key_q  <= in_key;
		end
		if (cmd.step) begin
			if (cur_occ && cur_key == key_q && !hit_q) hit_slot_q <= idx_q;
			if (!cur_occ && !free_q) free_slot_q <= idx_q;
			if (vic_take) begin
				vic_slot_q  <= idx_q;
				vic_stamp_q <= cur_stamp;
				vic_key_q   <= cur_key;
			end
		end
		if (cmd.commit) begin
			res_status_q <= nxt_status;
			res_slot_q   <= slot_ext[SLOT_W-1:0];
			res_evkey_q  <= (nxt_status == ST_EVICT) ? vic_key_q : '0;
			res_ev_q     <= (nxt_status == ST_EVICT);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q     <= '0;
			frame_q   <= '0;
			idx_q     <= '0;
			hit_q     <= 1'b0;
			free_q    <= 1'b0;
			vic_q     <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (cmd.capture) begin
				idx_q  <= '0;
				hit_q  <= 1'b0;
				free_q <= 1'b0;
				vic_q  <= 1'b0;
			end
			if (cmd.step) begin
				if (!stat.scan_last) idx_q <= idx_q + 1'b1;
				if (cur_occ && cur_key == key_q) hit_q <= 1'b1;
				if (!cur_occ) free_q <= 1'b1;
				if (vic_take) vic_q <= 1'b1;
			end
			if (cmd.commit) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
			if (cmd.commit) begin
				unique case (kind_q)
					KIND_ACCESS: begin
						if (!hit_q && free_q) occ_q[free_slot_q] <= 1'b1;
					end
					KIND_ADVANCE: begin
						if (frame_q != '1) frame_q <= frame_q + 1'b1;
					end
					KIND_FLUSH: begin
						occ_q   <= '0;
						frame_q <= '0;
					end
					KIND_NONE: ;
				endcase
			end
		end
	end

	assign out_valid = out_vld_q;
	assign out_word  = {res_ev_q, res_evkey_q, res_slot_q, res_status_q};

endmodule

`default_nettype wire

### rtl/frame_pinned_lru_entry_table_core.sv
// Top level of the frame-pinned LRU entry table: stream ports around the
// sequencer (fplet_ctrl) and the datapath (fplet_dp). Depends on fplet_pkg.
//
// One word in gives one word out. The accepting edge captures the word; for
// an access the scan then visits each slot in turn to find a hit, the lowest
// free slot and the oldest stamp below the current frame, and the commit state
// registers the result. Advance, flush and unknown kinds skip the scan and go
// straight to commit. The next word is accepted in the cycle after commit,
// while the result still waits in the output register, so no new word is
// taken while one is in the scan or commit states. A result still waiting at
// the next commit holds that commit, and with it the input.
`default_nettype none

module frame_pinned_lru_entry_table_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // key[31:0]
	input  wire logic [1:0]  s_tuser,   // kind[1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata    // status[2:0] slot[6:3] evicted_key[38:7] evicted[39]
);
	import fplet_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	fplet_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	fplet_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_kind   (s_tuser),
		.in_key    (s_tdata),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_word  (m_tdata)
	);

endmodule

`default_nettype wire

### bench/tb.sv
// Self-checking bench for frame_pinned_lru_entry_table_core: directed corners, random
// access traffic with frame advances and flushes, output back-pressure and a quiet gap.
// Depends on fplet_pkg and the core; predicts every result word in-bench.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fplet_pkg::*;

	localparam int QUIET_LIMIT = 5000;

	typedef struct {
		status_t     status;
		logic [3:0]  slot;
		logic [31:0] evicted_key;
		logic        evicted;
	} outcome_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic [1:0]  s_tuser = KIND_NONE;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;

	logic [31:0] slot_key [ENTRIES];
	logic [31:0] slot_stamp [ENTRIES];
	logic        slot_used [ENTRIES];
	logic [31:0] frame_no = '0;

	outcome_t    pending_outcomes [$];
	int          mismatch_count = 0;
	int          tx_idle_pct = 0;
	int          rx_idle_pct = 0;
	int          rx_hold_left = 0;
	int          quiet_cycles = 0;

	frame_pinned_lru_entry_table_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #1 clk = ~clk;

	function automatic outcome_t table_lookup(input kind_t kind, input logic [31:0] key);
		outcome_t res;
		int hit_i;
		int free_i;
		int old_i;
		res = '{status: ST_ACK, slot: 4'd0, evicted_key: 32'd0, evicted: 1'b0};
		hit_i = -1;
		free_i = -1;
		old_i = -1;
		case (kind)
			KIND_ACCESS: begin
				for (int i = 0; i < ENTRIES; i++)
					if (hit_i < 0 && slot_used[i] && slot_key[i] == key)
						hit_i = i;
				if (hit_i >= 0) begin
					slot_stamp[hit_i] = frame_no;
					res.status = ST_HIT;
					res.slot = hit_i[3:0];
				end else begin
					for (int i = 0; i < ENTRIES; i++) begin
						if (!slot_used[i]) begin
							if (free_i < 0)
								free_i = i;
						end else if (slot_stamp[i] < frame_no &&
							(old_i < 0 || slot_stamp[i] < slot_stamp[old_i])) begin
							old_i = i;
						end
					end
					if (free_i >= 0) begin
						slot_used[free_i] = 1'b1;
						slot_key[free_i] = key;
						slot_stamp[free_i] = frame_no;
						res.status = ST_ALLOC;
						res.slot = free_i[3:0];
					end else if (old_i < 0) begin
						res.status = ST_REFUSED;
					end else begin
						res.status = ST_EVICT;
						res.slot = old_i[3:0];
						res.evicted_key = slot_key[old_i];
						res.evicted = 1'b1;
						slot_key[old_i] = key;
						slot_stamp[old_i] = frame_no;
					end
				end
			end
			KIND_ADVANCE: begin
				if (frame_no != 32'hFFFF_FFFF)
					frame_no = frame_no + 1;
			end
			KIND_FLUSH: begin
				for (int i = 0; i < ENTRIES; i++)
					slot_used[i] = 1'b0;
				frame_no = '0;
			end
			default: ;
		endcase
		return res;
	endfunction

	task automatic flag_mismatch(input string field, input logic [31:0] got,
		input logic [31:0] want);
		mismatch_count++;
		$display("mismatch at %0t: %s got 0x%0h want 0x%0h", $realtime, field, got, want);
	endtask

	task automatic send_word(input kind_t kind, input logic [31:0] key);
		while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= key;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_outcomes.push_back(table_lookup(kind, key));
	endtask

	task automatic wait_all_results();
		s_tvalid <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_hit_and_alloc();
		send_word(KIND_ACCESS, 32'h0000_0000);
		send_word(KIND_ACCESS, 32'hFFFF_FFFF);
		send_word(KIND_ACCESS, 32'h0000_0000);
		send_word(KIND_NONE, 32'hDEAD_BEEF);
	endtask

	task automatic test_full_table();
		for (int i = 2; i < ENTRIES; i++)
			send_word(KIND_ACCESS, 32'h1000_0000 + i);
		send_word(KIND_ACCESS, 32'h1234_5678);
		send_word(KIND_ADVANCE, 32'h0);
		send_word(KIND_ACCESS, 32'h0000_0000);
		send_word(KIND_ACCESS, 32'hA5A5_A5A5);
		send_word(KIND_ADVANCE, 32'hFFFF_FFFF);
		send_word(KIND_FLUSH, 32'h0);
		send_word(KIND_ACCESS, 32'h5A5A_5A5A);
	endtask

	task automatic test_random_traffic(input int count, input int tx_pct, input int rx_pct);
		logic [31:0] key_pool [32];
		int pool_n;
		int roll;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		pool_n = $urandom_range(28, 12);
		for (int i = 0; i < 32; i++)
			key_pool[i] = $urandom;
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(99);
			if (roll < 8)
				send_word(KIND_ADVANCE, $urandom);
			else if (roll < 9)
				send_word(KIND_FLUSH, $urandom);
			else if (roll < 11)
				send_word(KIND_NONE, $urandom);
			else if (roll < 16)
				send_word(KIND_ACCESS, $urandom);
			else
				send_word(KIND_ACCESS, key_pool[$urandom_range(pool_n - 1)]);
		end
	endtask

	task automatic test_output_stall();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		rx_hold_left = 300;
		for (int n = 0; n < 12; n++)
			send_word(n % 4 == 3 ? KIND_ADVANCE : KIND_ACCESS, $urandom_range(7));
		wait_all_results();
		for (int n = 0; n < 8; n++)
			send_word(KIND_ACCESS, $urandom_range(7));
	endtask

	always @(posedge clk) begin
		if (rx_hold_left > 0) begin
			m_tready <= 1'b0;
			rx_hold_left = rx_hold_left - 1;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_outcomes.size() == 0) begin
				flag_mismatch("unexpected word", m_tdata[31:0], 32'd0);
			end else begin
				want = pending_outcomes.pop_front();
				if (m_tdata[2:0] != want.status)
					flag_mismatch("status", 32'(m_tdata[2:0]), 32'(want.status));
				if (m_tdata[6:3] != want.slot)
					flag_mismatch("slot", 32'(m_tdata[6:3]), 32'(want.slot));
				if (m_tdata[38:7] != want.evicted_key)
					flag_mismatch("evicted_key", m_tdata[38:7], want.evicted_key);
				if (m_tdata[39] != want.evicted)
					flag_mismatch("evicted", 32'(m_tdata[39]), 32'(want.evicted));
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb: errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		for (int i = 0; i < ENTRIES; i++) begin
			slot_used[i] = 1'b0;
			slot_key[i] = '0;
			slot_stamp[i] = '0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_hit_and_alloc();
		test_full_table();
		test_random_traffic(270, 38, 71);
		test_random_traffic(270, 71, 38);
		test_random_traffic(270, 0, 0);
		test_output_stall();
		wait_all_results();
		repeat (ENTRIES + 8) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
